FILE: src/stsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsg_pkg
// Shared types and constants of the scope trace span generator.
// ----------------------------------------------------------------------------
package stsg_pkg;

   localparam int COORD_BITS = 12;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   localparam int DIM_BITS    = 13;
   localparam int GAIN_BITS   = 16;
   localparam int MODE_BITS   = 2;
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Q1.15 sample times Q4.12 gain leaves 27 fraction bits
   localparam int FRAC_BITS = 27;
   localparam int PROD1_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int PROD2_BITS = PROD1_BITS + COORD_BITS + 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE_GAIN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCOPE_MODE     = 2'd3;

   localparam logic [MODE_BITS-1:0] MODE_LINES = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DOTS  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SOLID = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_NONE  = 2'd3;

   localparam logic [DIM_BITS-1:0]  RESET_SCREEN_WIDTH  = 13'd512;
   localparam logic [DIM_BITS-1:0]  RESET_SCREEN_HEIGHT = 13'd256;
   localparam logic [GAIN_BITS-1:0] RESET_GAIN          = 16'd4096;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCALE = 5'b00010,
      ST_ROW   = 5'b00100,
      ST_FORM  = 5'b01000,
      ST_WAIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;  // take the sample and form sample * gain
      logic scale;    // multiply by half the screen height
      logic row;      // floor, offset and clamp the row
      logic form;     // build the span into the output register
   } cmd_type;

endpackage
`default_nettype wire

FILE: src/stsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsg_ctrl
// Sequencer: steps one sample through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module stsg_ctrl
   import stsg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   assign slot_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ROW;
         end
         ST_ROW: begin
            cmd.row  = 1'b1;
            state_in = ST_FORM;
         end
         ST_FORM, ST_WAIT: begin
            // hold until the previous beat has left the output register
            if (slot_free) begin
               cmd.form     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule
`default_nettype wire

FILE: src/stsg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsg_datapath
// Configuration registers, row scaling, column and previous-row state, span.
// ----------------------------------------------------------------------------
module stsg_datapath
   import stsg_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   input  wire logic                         csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_write_data,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  wire logic                         req_frame_start,
   output logic [COORD_BITS-1:0]             rsp_column_index,
   output logic [COORD_BITS-1:0]             rsp_span_top,
   output logic [COORD_BITS-1:0]             rsp_span_bottom,
   output logic                              rsp_draw_enable,
   output logic                              rsp_last_column
);

   logic [DIM_BITS-1:0]  width_ff, height_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   logic [MODE_BITS-1:0] mode_ff;

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] prev_ff, prev_in;

   logic signed [PROD1_BITS-1:0] p1_ff;
   logic signed [PROD2_BITS-1:0] p2_ff;
   logic                         fs_ff;
   logic [COORD_BITS-1:0]        row_ff, row_in;

   logic [COORD_BITS-1:0] col_out_ff, top_ff, bot_ff;
   logic                  draw_ff, last_ff;

   logic [COORD_BITS-1:0]         half;
   logic signed [COORD_BITS:0]    half_s;
   logic signed [PROD2_BITS-FRAC_BITS-1:0] q;
   logic signed [PROD2_BITS-FRAC_BITS:0]   y_full;
   logic [DIM_BITS-1:0]           h_m1;
   logic [COORD_BITS-1:0]         lim;

   logic [DIM_BITS-1:0]   width_eff;
   logic [COORD_BITS-1:0] col, prev, a_sel, top_in, bot_in;
   logic [COORD_BITS:0]   col_inc;
   logic                  last_in, draw_in;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SCREEN_WIDTH;
         height_ff <= RESET_SCREEN_HEIGHT;
         gain_ff   <= RESET_GAIN;
         mode_ff   <= MODE_LINES;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:   width_ff  <= csr_write_data[DIM_BITS-1:0];
            CSR_SCREEN_HEIGHT:  height_ff <= csr_write_data[DIM_BITS-1:0];
            CSR_AMPLITUDE_GAIN: gain_ff   <= csr_write_data[GAIN_BITS-1:0];
            CSR_SCOPE_MODE:     mode_ff   <= csr_write_data[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---- row ----
   assign half   = height_ff[DIM_BITS-1:1];
   assign half_s = $signed({1'b0, half});
   // arithmetic shift floors toward minus infinity
   assign q      = p2_ff[PROD2_BITS-1:FRAC_BITS];
   assign y_full = {q[$bits(q)-1], q}
                 + $signed({{($bits(y_full)-COORD_BITS){1'b0}}, half});
   assign h_m1   = height_ff - DIM_BITS'(1);

   always_comb begin
      if (height_ff == '0) begin
         lim = '0;
      end else if (h_m1 > DIM_BITS'(COORD_MAX)) begin
         lim = COORD_MAX;
      end else begin
         lim = h_m1[COORD_BITS-1:0];
      end
      if (y_full[$bits(y_full)-1]) begin
         row_in = '0;
      end else if (y_full > $signed({{($bits(y_full)-COORD_BITS){1'b0}}, lim})) begin
         row_in = lim;
      end else begin
         row_in = y_full[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         p1_ff <= req_sample_value * $signed({1'b0, gain_ff});
         fs_ff <= req_frame_start;
      end
      if (cmd.scale) begin
         p2_ff <= p1_ff * half_s;
      end
      if (cmd.row) begin
         row_ff <= row_in;
      end
   end

   // ---- span ----
   always_comb begin
      width_eff = (width_ff == '0) ? DIM_BITS'(1) : width_ff;
      col       = fs_ff ? '0 : column_ff;
      prev      = fs_ff ? row_ff : prev_ff;
      col_inc   = {1'b0, col} + (COORD_BITS+1)'(1);
      last_in   = (col_inc >= width_eff) || (col == COORD_MAX);
      column_in = last_in ? '0 : col_inc[COORD_BITS-1:0];
      prev_in   = prev;
      a_sel     = half;
      top_in    = row_ff;
      bot_in    = row_ff;
      draw_in   = 1'b0;
      case (mode_ff)
         MODE_LINES, MODE_SOLID: begin
            a_sel   = (mode_ff == MODE_LINES) ? prev : half;
            top_in  = (a_sel < row_ff) ? a_sel : row_ff;
            bot_in  = (a_sel < row_ff) ? row_ff : a_sel;
            draw_in = ({1'b0, bot_in} < height_ff);
            if (mode_ff == MODE_LINES) begin
               prev_in = row_ff;
            end
         end
         MODE_DOTS: begin
            draw_in = (col != '0) && ({1'b0, col} < width_ff) && (row_ff != '0);
         end
         default: begin
            draw_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         prev_ff   <= '0;
      end else if (cmd.form) begin
         column_ff <= column_in;
         prev_ff   <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         col_out_ff <= col;
         top_ff     <= top_in;
         bot_ff     <= bot_in;
         draw_ff    <= draw_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_column_index = col_out_ff;
   assign rsp_span_top     = top_ff;
   assign rsp_span_bottom  = bot_ff;
   assign rsp_draw_enable  = draw_ff;
   assign rsp_last_column  = last_ff;

endmodule
`default_nettype wire

FILE: src/scope_trace_span_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_trace_span_generator_core
// Turns one audio sample per screen column into a vertical trace span.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   sample_value, frame_start
//   rsp      out        rsp_valid / rsp_stall   column_index, span_top,
//                                               span_bottom, draw_enable,
//                                               last_column
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// A sample is worked in four steps, one per clock edge starting at the
// accepting edge: gain multiply, height multiply, floor and clamp, span build;
// the span build waits while the previous beat is still stalled on rsp.
// The sequencer handles one sample at a time, so it takes no new sample
// until the last one's span is built. The next sample is taken while a beat
// still waits on rsp. Synchronous reset restores the register defaults and
// clears the column and previous row.
// ----------------------------------------------------------------------------
module scope_trace_span_generator_core
   import stsg_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  wire logic                          req_frame_start,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [COORD_BITS-1:0]              rsp_column_index,
   output logic [COORD_BITS-1:0]              rsp_span_top,
   output logic [COORD_BITS-1:0]              rsp_span_bottom,
   output logic                               rsp_draw_enable,
   output logic                               rsp_last_column,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   cmd_type cmd;

   stsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   stsg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample_value (req_sample_value),
      .req_frame_start  (req_frame_start),
      .rsp_column_index (rsp_column_index),
      .rsp_span_top     (rsp_span_top),
      .rsp_span_bottom  (rsp_span_bottom),
      .rsp_draw_enable  (rsp_draw_enable),
      .rsp_last_column  (rsp_last_column)
   );

endmodule
`default_nettype wire

FILE: src/stsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsg_checker
// Port-level checks on the span generator, bound to the top level.
// ----------------------------------------------------------------------------
module stsg_checker
   import stsg_pkg::*;
(
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [COORD_BITS-1:0]         rsp_column_index,
   input wire logic [COORD_BITS-1:0]         rsp_span_top,
   input wire logic [COORD_BITS-1:0]         rsp_span_bottom,
   input wire logic                          rsp_draw_enable,
   input wire logic                          rsp_last_column
);

   // a stalled beat stays up with its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column_index)
         && $stable(rsp_span_top) && $stable(rsp_span_bottom)
         && $stable(rsp_draw_enable) && $stable(rsp_last_column))
      else $error("rsp beat changed while stalled");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_top <= rsp_span_bottom)
      else $error("span top below span bottom");

   // the sequencer stays busy through the scale, row and span-build steps after taking a sample
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall)
      else $error("sample taken while previous one in flight");

   // a beat can only appear after a sample was taken
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("beat appeared without a sample in flight");

endmodule

bind scope_trace_span_generator_core stsg_checker u_stsg_checker (.*);
`default_nettype wire
